// ===== hdl/gcld_pkg.sv =====
package gcld_pkg;

    // Widths of the position path and of the output coordinates
    localparam int COORD_BITS = 24;
    localparam int POS_W      = 24;

    // Command slot value that means "expect a command word"
    localparam logic [2:0] SLOT_IDLE = 3'd4;

    // Result queue between decode and output
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Packed output data width, whole bytes
    localparam int DATA_W = 160;

    // Result kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_BEGIN  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Geometry command codes
    localparam logic [7:0] CMD_MTX_MODE      = 8'h10;
    localparam logic [7:0] CMD_MTX_POP       = 8'h12;
    localparam logic [7:0] CMD_MTX_STORE     = 8'h13;
    localparam logic [7:0] CMD_MTX_RESTORE   = 8'h14;
    localparam logic [7:0] CMD_MTX_LOAD_4X4  = 8'h16;
    localparam logic [7:0] CMD_MTX_LOAD_4X3  = 8'h17;
    localparam logic [7:0] CMD_MTX_MULT_4X4  = 8'h18;
    localparam logic [7:0] CMD_MTX_MULT_4X3  = 8'h19;
    localparam logic [7:0] CMD_MTX_MULT_3X3  = 8'h1A;
    localparam logic [7:0] CMD_MTX_SCALE     = 8'h1B;
    localparam logic [7:0] CMD_MTX_TRANS     = 8'h1C;
    localparam logic [7:0] CMD_COLOR         = 8'h20;
    localparam logic [7:0] CMD_NORMAL        = 8'h21;
    localparam logic [7:0] CMD_TEXCOORD      = 8'h22;
    localparam logic [7:0] CMD_VTX_16        = 8'h23;
    localparam logic [7:0] CMD_VTX_10        = 8'h24;
    localparam logic [7:0] CMD_VTX_XY        = 8'h25;
    localparam logic [7:0] CMD_VTX_XZ        = 8'h26;
    localparam logic [7:0] CMD_VTX_YZ        = 8'h27;
    localparam logic [7:0] CMD_VTX_DIFF      = 8'h28;
    localparam logic [7:0] CMD_POLYGON_ATTR  = 8'h29;
    localparam logic [7:0] CMD_TEXIMAGE      = 8'h2A;
    localparam logic [7:0] CMD_PLTT_BASE     = 8'h2B;
    localparam logic [7:0] CMD_DIF_AMB       = 8'h30;
    localparam logic [7:0] CMD_SPE_EMI       = 8'h31;
    localparam logic [7:0] CMD_LIGHT_VECTOR  = 8'h32;
    localparam logic [7:0] CMD_LIGHT_COLOR   = 8'h33;
    localparam logic [7:0] CMD_SHININESS     = 8'h34;
    localparam logic [7:0] CMD_BEGIN_VTXS    = 8'h40;
    localparam logic [7:0] CMD_END_VTXS      = 8'h41;
    localparam logic [7:0] CMD_SWAP_BUFFERS  = 8'h50;
    localparam logic [7:0] CMD_VIEWPORT      = 8'h60;
    localparam logic [7:0] CMD_BOX_TEST      = 8'h70;
    localparam logic [7:0] CMD_POS_TEST      = 8'h71;
    localparam logic [7:0] CMD_VEC_TEST      = 8'h72;

    // One queue entry: one or two results made by a single input word.
    // With two set, a primitive end with the same attributes follows.
    typedef struct packed {
        logic [1:0]       kind;
        logic             two;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [14:0]      color_rgb;
        logic [29:0]      normal_packed;
        logic [31:0]      texcoord;
        logic [4:0]       matrix_index;
        logic [1:0]       prim_type;
    } t_entry;

    // One result on the output side
    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [14:0]      color_rgb;
        logic [29:0]      normal_packed;
        logic [31:0]      texcoord;
        logic [4:0]       matrix_index;
        logic [1:0]       prim_type;
        logic             run_last;
    } t_result;

    // Number of parameter words each command takes
    function automatic logic [5:0] param_count(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            CMD_MTX_MODE, CMD_MTX_POP, CMD_MTX_STORE, CMD_MTX_RESTORE: k = 6'd1;
            CMD_MTX_LOAD_4X4, CMD_MTX_MULT_4X4:                        k = 6'd16;
            CMD_MTX_LOAD_4X3, CMD_MTX_MULT_4X3:                        k = 6'd12;
            CMD_MTX_MULT_3X3:                                          k = 6'd9;
            CMD_MTX_SCALE, CMD_MTX_TRANS, CMD_BOX_TEST:                k = 6'd3;
            CMD_VTX_16, CMD_POS_TEST:                                  k = 6'd2;
            CMD_SHININESS:                                             k = 6'd32;
            CMD_COLOR, CMD_NORMAL, CMD_TEXCOORD, CMD_VTX_10,
            CMD_VTX_XY, CMD_VTX_XZ, CMD_VTX_YZ, CMD_VTX_DIFF,
            CMD_POLYGON_ATTR, CMD_TEXIMAGE, CMD_PLTT_BASE,
            CMD_DIF_AMB, CMD_SPE_EMI, CMD_LIGHT_VECTOR,
            CMD_LIGHT_COLOR, CMD_BEGIN_VTXS, CMD_SWAP_BUFFERS,
            CMD_VIEWPORT, CMD_VEC_TEST:                                k = 6'd1;
            default:                                                   k = 6'd0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/geometry_command_list_decoder.sv =====
// Packed geometry command list decoder. Display list words enter on the slave
// stream, one 32-bit word per transaction; tlast marks the final word of a list,
// after which all decoder state returns to its reset value (the scale register
// is kept). A command word carries four command bytes, run from the low byte
// up, and the parameter words of each command follow it. The decoder tracks
// the current colour, normal, texcoord, matrix index, open primitive and last
// vertex, and emits vertex, begin and end results on the master stream with
// tlast set on the last result a word produced. The scale register may be
// written only while the block is idle. Rate: one word per clock while the
// result queue is not full; the front end decodes and executes a word in the
// cycle it is accepted. A word yields at most two results (a begin or vertex
// then an end), both taken from one queue entry; a four-entry result queue
// lets the front end keep accepting words while the output side stalls or
// drains a pair. Results pass through the queue, then the output register.
module geometry_command_list_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // scale register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_data,   // coordinate left shift
    // display list words
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [31:0]                 i_s_tdata,    // word
    input  logic                        i_s_tlast,    // last_word
    // results
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // pos_x[23:0], pos_y[47:24], pos_z[71:48], color_rgb[86:72],
    // normal_packed[116:87], texcoord[148:117], matrix_index[153:149],
    // prim_type[155:154], zero[159:156]
    output logic [gcld_pkg::DATA_W-1:0] o_m_tdata,
    output logic [1:0]                  o_m_tuser,    // kind
    output logic                        o_m_tlast     // run_last
);

    localparam int USED_W = 3 * gcld_pkg::POS_W + 15 + 30 + 32 + 5 + 2;

    logic              q_full;
    logic              q_valid;
    logic              q_push;
    logic              q_pop;
    gcld_pkg::t_entry  q_in;
    gcld_pkg::t_entry  q_head;
    gcld_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    gcld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .i_word      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_full      (q_full),
        .o_ready     (o_s_tready),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    gcld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    gcld_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_result (res)
    );

    // Pack result fields, first field in the low bits
    assign o_m_tdata = {{(gcld_pkg::DATA_W - USED_W){1'b0}},
                        res.prim_type, res.matrix_index, res.texcoord,
                        res.normal_packed, res.color_rgb,
                        res.pos_z, res.pos_y, res.pos_x};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.run_last;

endmodule

// ===== hdl/gcld_front.sv =====
module gcld_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_data,
    input  logic                  i_valid,
    input  logic [31:0]           i_word,
    input  logic                  i_last,
    input  logic                  i_full,
    output logic                  o_ready,
    output logic                  o_push,
    output gcld_pkg::t_entry      o_entry
);

    localparam int CB = gcld_pkg::COORD_BITS;

    // Decoder state
    logic [2:0]    r_scale;
    logic [31:0]   r_cmds,   n_cmds;
    logic [2:0]    r_slot,   n_slot;
    logic [5:0]    r_left,   n_left;
    logic [31:0]   r_hold,   n_hold;
    logic [14:0]   r_color,  n_color;
    logic [29:0]   r_normal, n_normal;
    logic [31:0]   r_tex,    n_tex;
    logic [4:0]    r_mtx,    n_mtx;
    logic [CB-1:0] r_pos [0:2];
    logic [CB-1:0] n_pos [0:2];
    logic          r_open,   n_open;
    logic [1:0]    r_type,   n_type;

    logic          fire;
    logic          is_cmd;
    logic [7:0]    cur_cmd;
    logic          exec_go;
    logic          exec_vtx;
    logic          exec_emit;
    logic [1:0]    exec_kind;
    logic          adv_go;
    logic [2:0]    adv_start;
    logic          adv_stop;
    logic          adv_open;
    logic [7:0]    adv_byte;
    logic [5:0]    adv_cnt;
    logic          end_emit;
    logic [3:0]    sh0;
    logic [3:0]    sh6;

    function automatic logic [CB-1:0] f_sx16(input logic [15:0] v);
        return {{(CB-16){v[15]}}, v};
    endfunction

    function automatic logic [CB-1:0] f_sx10(input logic [9:0] v);
        return {{(CB-10){v[9]}}, v};
    endfunction

    function automatic logic [CB-1:0] f_shl(input logic [CB-1:0] v, input logic [3:0] sh);
        return v << sh;
    endfunction

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;
    assign sh0     = {1'b0, r_scale};
    assign sh6     = {1'b0, r_scale} + 4'd6;

    // Classify the word, run a completed command, then walk the command slots
    always_comb begin
        n_cmds    = r_cmds;
        n_slot    = r_slot;
        n_left    = r_left;
        n_hold    = r_hold;
        n_color   = r_color;
        n_normal  = r_normal;
        n_tex     = r_tex;
        n_mtx     = r_mtx;
        n_pos     = r_pos;
        n_open    = r_open;
        n_type    = r_type;
        exec_go   = 1'b0;
        exec_vtx  = 1'b0;
        exec_emit = 1'b0;
        exec_kind = gcld_pkg::KIND_VERTEX;
        adv_go    = 1'b0;
        adv_start = 3'd0;
        adv_stop  = 1'b0;
        adv_open  = 1'b0;
        adv_byte  = 8'd0;
        adv_cnt   = 6'd0;
        end_emit  = 1'b0;

        is_cmd  = r_slot[2] || (r_left == 6'd0);
        cur_cmd = r_cmds[{r_slot[1:0], 3'b000} +: 8];

        if (is_cmd) begin
            n_cmds    = i_word;
            adv_go    = 1'b1;
            adv_start = 3'd0;
        end else begin
            if (cur_cmd == gcld_pkg::CMD_VTX_16 && r_left == 6'd2) begin
                n_hold = i_word;
            end
            n_left = r_left - 6'd1;
            if (n_left == 6'd0) begin
                exec_go   = 1'b1;
                adv_go    = 1'b1;
                adv_start = r_slot + 3'd1;
            end
        end

        // Execute the command whose last parameter is this word
        if (exec_go) begin
            case (cur_cmd)
                gcld_pkg::CMD_MTX_RESTORE: n_mtx    = i_word[4:0];
                gcld_pkg::CMD_COLOR:       n_color  = i_word[14:0];
                gcld_pkg::CMD_NORMAL:      n_normal = i_word[29:0];
                gcld_pkg::CMD_TEXCOORD:    n_tex    = i_word;
                gcld_pkg::CMD_VTX_16: begin
                    exec_vtx = 1'b1;
                    n_pos[0] = f_shl(f_sx16(r_hold[15:0]), sh0);
                    n_pos[1] = f_shl(f_sx16(r_hold[31:16]), sh0);
                    n_pos[2] = f_shl(f_sx16(i_word[15:0]), sh0);
                end
                gcld_pkg::CMD_VTX_10: begin
                    exec_vtx = 1'b1;
                    n_pos[0] = f_shl(f_sx10(i_word[9:0]), sh6);
                    n_pos[1] = f_shl(f_sx10(i_word[19:10]), sh6);
                    n_pos[2] = f_shl(f_sx10(i_word[29:20]), sh6);
                end
                gcld_pkg::CMD_VTX_XY: begin
                    exec_vtx = 1'b1;
                    n_pos[0] = f_shl(f_sx16(i_word[15:0]), sh0);
                    n_pos[1] = f_shl(f_sx16(i_word[31:16]), sh0);
                end
                gcld_pkg::CMD_VTX_XZ: begin
                    exec_vtx = 1'b1;
                    n_pos[0] = f_shl(f_sx16(i_word[15:0]), sh0);
                    n_pos[2] = f_shl(f_sx16(i_word[31:16]), sh0);
                end
                gcld_pkg::CMD_VTX_YZ: begin
                    exec_vtx = 1'b1;
                    n_pos[1] = f_shl(f_sx16(i_word[15:0]), sh0);
                    n_pos[2] = f_shl(f_sx16(i_word[31:16]), sh0);
                end
                gcld_pkg::CMD_VTX_DIFF: begin
                    exec_vtx = 1'b1;
                    n_pos[0] = r_pos[0] + f_shl(f_sx10(i_word[9:0]), sh0);
                    n_pos[1] = r_pos[1] + f_shl(f_sx10(i_word[19:10]), sh0);
                    n_pos[2] = r_pos[2] + f_shl(f_sx10(i_word[29:20]), sh0);
                end
                gcld_pkg::CMD_BEGIN_VTXS: begin
                    n_type    = i_word[1:0];
                    n_open    = 1'b1;
                    exec_emit = 1'b1;
                    exec_kind = gcld_pkg::KIND_BEGIN;
                end
                default: ;
            endcase
            if (exec_vtx && r_open) begin
                exec_emit = 1'b1;
                exec_kind = gcld_pkg::KIND_VERTEX;
            end
        end

        // Walk the slots up to the next command that waits for parameters, closing an open primitive at END_VTXS
        if (adv_go) begin
            adv_open = n_open;
            for (int i = 0; i < 4; i++) begin
                if (3'(i) >= adv_start && !adv_stop) begin
                    adv_byte = n_cmds[8*i +: 8];
                    adv_cnt  = gcld_pkg::param_count(adv_byte);
                    if (adv_cnt != 6'd0) begin
                        adv_stop = 1'b1;
                        n_slot   = 3'(i);
                        n_left   = adv_cnt;
                    end else if (adv_byte == gcld_pkg::CMD_END_VTXS && adv_open) begin
                        end_emit = 1'b1;
                        adv_open = 1'b0;
                    end
                end
            end
            n_open = adv_open;
            if (!adv_stop) begin
                n_slot = gcld_pkg::SLOT_IDLE;
                n_left = 6'd0;
            end
        end
    end

    // Build the queue entry from the updated attributes
    always_comb begin
        o_push                = fire && (exec_emit || end_emit);
        o_entry.kind          = exec_emit ? exec_kind : gcld_pkg::KIND_END;
        o_entry.two           = exec_emit && end_emit;
        o_entry.color_rgb     = n_color;
        o_entry.normal_packed = n_normal;
        o_entry.texcoord      = n_tex;
        o_entry.matrix_index  = n_mtx;
        o_entry.prim_type     = n_type;
        if (exec_emit && exec_kind == gcld_pkg::KIND_VERTEX) begin
            o_entry.pos_x = n_pos[0][gcld_pkg::POS_W-1:0];
            o_entry.pos_y = n_pos[1][gcld_pkg::POS_W-1:0];
            o_entry.pos_z = n_pos[2][gcld_pkg::POS_W-1:0];
        end else begin
            o_entry.pos_x = '0;
            o_entry.pos_y = '0;
            o_entry.pos_z = '0;
        end
    end

    // Hold the decoder state; end of list returns it to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && i_last)) begin
            r_cmds   <= '0;
            r_slot   <= gcld_pkg::SLOT_IDLE;
            r_left   <= '0;
            r_hold   <= '0;
            r_color  <= '0;
            r_normal <= '0;
            r_tex    <= '0;
            r_mtx    <= '0;
            r_pos    <= '{default: '0};
            r_open   <= 1'b0;
            r_type   <= '0;
        end else if (fire) begin
            r_cmds   <= n_cmds;
            r_slot   <= n_slot;
            r_left   <= n_left;
            r_hold   <= n_hold;
            r_color  <= n_color;
            r_normal <= n_normal;
            r_tex    <= n_tex;
            r_mtx    <= n_mtx;
            r_pos    <= n_pos;
            r_open   <= n_open;
            r_type   <= n_type;
        end
    end

    // Take the scale register; it survives the end of a list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= gcld_pkg::SLOT_IDLE)
        else $error("command slot beyond idle");

    a_slot_has_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != gcld_pkg::SLOT_IDLE |-> r_left != 6'd0)
        else $error("command slot parked with no parameters outstanding");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_last |=> r_slot == gcld_pkg::SLOT_IDLE && !r_open && r_left == 6'd0)
        else $error("state not cleared after end of list");

endmodule

// ===== hdl/gcld_queue.sv =====
module gcld_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gcld_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output gcld_pkg::t_entry o_head
);

    localparam int PTR_W = gcld_pkg::QPTR_W;
    localparam int CNT_W = gcld_pkg::QPTR_W + 1;

    gcld_pkg::t_entry              r_mem [0:gcld_pkg::QUEUE_DEPTH-1];
    logic [gcld_pkg::QPTR_W-1:0]   r_wr;
    logic [gcld_pkg::QPTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]              r_count;

    assign o_full  = (r_count == CNT_W'(gcld_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty result queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(gcld_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

endmodule

// ===== hdl/gcld_back.sv =====
module gcld_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gcld_pkg::t_entry  i_head,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output gcld_pkg::t_result o_result
);

    logic              r_valid;
    logic              r_phase;
    gcld_pkg::t_result r_result;
    gcld_pkg::t_result n_result;
    logic              load;

    assign load     = !r_valid || i_ready;
    assign o_pop    = load && i_valid && (!i_head.two || r_phase);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Split an entry into its first result and an optional trailing end
    always_comb begin
        n_result.kind          = r_phase ? gcld_pkg::KIND_END : i_head.kind;
        n_result.pos_x         = r_phase ? '0 : i_head.pos_x;
        n_result.pos_y         = r_phase ? '0 : i_head.pos_y;
        n_result.pos_z         = r_phase ? '0 : i_head.pos_z;
        n_result.color_rgb     = i_head.color_rgb;
        n_result.normal_packed = i_head.normal_packed;
        n_result.texcoord      = i_head.texcoord;
        n_result.matrix_index  = i_head.matrix_index;
        n_result.prim_type     = i_head.prim_type;
        n_result.run_last      = r_phase || !i_head.two;
    end

    // Hold the output register and the second-result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_phase <= i_head.two && !r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_result <= n_result;
        end
    end

    a_phase_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_valid && i_head.two)
        else $error("second result pending without its entry");

    a_phase_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_valid && !r_result.run_last)
        else $error("first of two results not on the output");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_result))
        else $error("stalled result changed before acceptance");

endmodule
